/* hdl/sorted_list_insert_delete_find_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sorted list block
// Concurrent property wrappers clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_DELETE_FIND_MACROS_SVH
`define SORTED_LIST_INSERT_DELETE_FIND_MACROS_SVH

// same-cycle implication
`define SLI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted list assertion failed");

// next-cycle implication
`define SLI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted list assertion failed");

`endif

/* hdl/sli_pkg.sv */
// ----------------------------------------------------------------------------
// sli_pkg
// Types and constants shared by the sorted list cells, top level and checker.
// ----------------------------------------------------------------------------
package sli_pkg;

  localparam int unsigned ValueW       = 32;
  localparam int unsigned PosW         = 5;
  localparam int unsigned SumW         = 36;
  localparam int unsigned AccW         = 37;
  localparam int unsigned DefaultDepth = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // broadcast to every cell of the row
  typedef struct packed {
    logic                     ins_en;
    logic                     del_en;
    logic signed [ValueW-1:0] value;
  } cell_ctrl_t;

endpackage

/* hdl/sli_in_if.sv */
// ----------------------------------------------------------------------------
// sli_in_if
// Request channel: operation code and value, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sli_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       operation;
  logic signed [sli_pkg::ValueW-1:0] value;

  modport source (output valid, operation, value, input ready);
  modport sink   (input valid, operation, value, output ready);
endinterface

/* hdl/sli_out_if.sv */
// ----------------------------------------------------------------------------
// sli_out_if
// Result channel: status, position, entry count and sum, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sli_out_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      status;
  logic [sli_pkg::PosW-1:0]        position;
  logic [sli_pkg::PosW-1:0]        entry_count;
  logic signed [sli_pkg::SumW-1:0] value_sum;

  modport source (output valid, status, position, entry_count, value_sum, input ready);
  modport sink   (input valid, status, position, entry_count, value_sum, output ready);
endinterface

/* hdl/sli_cell.sv */
// ----------------------------------------------------------------------------
// sli_cell
// One slot of the sorted row: compares its entry against the broadcast value
// and takes its own, the new, the left or the right neighbor's entry.
// ----------------------------------------------------------------------------
module sli_cell (
  input  logic                              clk_i,
  input  sli_pkg::cell_ctrl_t               ctrl_i,
  input  logic                              occ_i,
  input  logic signed [sli_pkg::ValueW-1:0] left_entry_i,
  input  logic signed [sli_pkg::ValueW-1:0] right_entry_i,
  input  logic                              left_lt_i,
  input  logic                              left_seen_i,
  output logic signed [sli_pkg::ValueW-1:0] entry_o,
  output logic                              lt_o,
  output logic                              seen_o,
  output logic                              first_o
);

  logic signed [sli_pkg::ValueW-1:0] entry_q, entry_d;
  logic                              eq;

  assign lt_o    = occ_i && (entry_q < ctrl_i.value);
  assign eq      = occ_i && (entry_q == ctrl_i.value);
  assign seen_o  = left_seen_i | eq;
  assign first_o = eq & ~left_seen_i;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins_en) begin
      // entries below the value stay, the boundary slot takes the value,
      // everything above moves one slot up
      if (!lt_o) begin
        entry_d = left_lt_i ? ctrl_i.value : left_entry_i;
      end
    end else if (ctrl_i.del_en) begin
      // from the first match upward, close the gap
      if (seen_o) begin
        entry_d = right_entry_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

/* hdl/sorted_list_insert_delete_find.sv */
// Sorted list of up to DEPTH signed 32-bit values held in a row of cells, one
// value per cell, kept in ascending order. Each accepted transaction inserts,
// deletes or looks up one value and produces exactly one result in an output
// register in the next cycle; a new transaction is taken every cycle while
// that register is empty or being drained, so the sustained rate is one item
// per clock. All cells compare in parallel and shift in the same cycle; the
// first-match flag ripples through the DEPTH cells, which sets the clock path.
// Stored values come up undefined; only slots below the count are ever used.
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_find
// Top level: cell row, entry count, running sum and result register.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_find #(
  parameter int unsigned DEPTH = sli_pkg::DefaultDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  sli_in_if.sink           in_i,
  sli_out_if.source        out_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic                              accept;
  logic                              is_ins, is_del, is_find;
  logic                              full, found;
  logic [CntW-1:0]                   count_q, count_d;
  logic signed [sli_pkg::AccW-1:0]   sum_q, sum_d, value_ext;
  sli_pkg::cell_ctrl_t               ctrl;

  logic signed [sli_pkg::ValueW-1:0] entries [DEPTH];
  logic [DEPTH:0]                    lt_chain;
  logic [DEPTH:0]                    seen_chain;
  logic [DEPTH-1:0]                  first;
  logic [DEPTH-1:0]                  occ;
  logic [sli_pkg::PosW-1:0]          pos;

  logic                              out_valid_q;
  sli_pkg::status_e                  status_q, status_d;
  logic [sli_pkg::PosW-1:0]          position_q, position_d;
  logic [sli_pkg::PosW-1:0]          count_out_q;
  logic signed [sli_pkg::SumW-1:0]   sum_out_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign is_ins  = (in_i.operation == sli_pkg::OP_INSERT);
  assign is_del  = (in_i.operation == sli_pkg::OP_DELETE);
  assign is_find = (in_i.operation == sli_pkg::OP_FIND);

  assign full  = (count_q == CntW'(DEPTH));
  assign found = seen_chain[DEPTH];

  assign ctrl.ins_en = accept && is_ins && !full;
  assign ctrl.del_en = accept && is_del && found;
  assign ctrl.value  = in_i.value;

  assign lt_chain[0]   = 1'b1;
  assign seen_chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [sli_pkg::ValueW-1:0] left_entry, right_entry;

    assign occ[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_left_edge
      assign left_entry = in_i.value;
    end else begin : g_left
      assign left_entry = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_right_edge
      assign right_entry = '0;
    end else begin : g_right
      assign right_entry = entries[i+1];
    end

    sli_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occ_i         (occ[i]),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .left_lt_i     (lt_chain[i]),
      .left_seen_i   (seen_chain[i]),
      .entry_o       (entries[i]),
      .lt_o          (lt_chain[i+1]),
      .seen_o        (seen_chain[i+1]),
      .first_o       (first[i])
    );
  end

  // first[] is one-hot when a match exists
  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first[i]) begin
        pos = pos | sli_pkg::PosW'(i + 1);
      end
    end
  end

  assign value_ext = {{(sli_pkg::AccW - sli_pkg::ValueW){in_i.value[sli_pkg::ValueW-1]}},
                      in_i.value};

  always_comb begin
    count_d    = count_q;
    sum_d      = sum_q;
    status_d   = sli_pkg::ST_OK;
    position_d = '0;
    if (is_ins) begin
      if (full) begin
        status_d = sli_pkg::ST_FULL;
      end else begin
        count_d = count_q + CntW'(1);
        sum_d   = sum_q + value_ext;
      end
    end else if (is_del) begin
      if (found) begin
        count_d = count_q - CntW'(1);
        sum_d   = sum_q - value_ext;
      end else begin
        status_d = sli_pkg::ST_NOT_FOUND;
      end
    end else if (is_find) begin
      if (found) begin
        position_d = pos;
      end else begin
        status_d = sli_pkg::ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        sum_q       <= sum_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      position_q  <= position_d;
      count_out_q <= sli_pkg::PosW'(count_d);
      sum_out_q   <= sum_d[sli_pkg::SumW-1:0];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.position    = position_q;
  assign out_o.entry_count = count_out_q;
  assign out_o.value_sum   = sum_out_q;

endmodule

/* hdl/sli_checker.sv */
// ----------------------------------------------------------------------------
// sli_checker
// Port-level checks on the sorted list, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_list_insert_delete_find_macros.svh"

module sli_checker #(
  parameter int unsigned DEPTH = sli_pkg::DefaultDepth
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [1:0]                      out_status_i,
  input logic [sli_pkg::PosW-1:0]        out_position_i,
  input logic [sli_pkg::PosW-1:0]        out_entry_count_i,
  input logic signed [sli_pkg::SumW-1:0] out_value_sum_i
);

  logic out_stall;

  assign out_stall = out_valid_i && !out_ready_i;

  // every accepted transaction shows a result on the next cycle
  `SLI_ASSERT_NEXT(a_accept_result, in_valid_i && in_ready_i, out_valid_i)

  // refused or missed operations never carry a position
  `SLI_ASSERT_IMP(a_miss_no_pos, out_valid_i && out_status_i != sli_pkg::ST_OK, out_position_i == '0)

  // a refused insert means the list is at capacity
  `SLI_ASSERT_IMP(a_full_count, out_valid_i && out_status_i == sli_pkg::ST_FULL, out_entry_count_i == sli_pkg::PosW'(DEPTH))

  // a stalled result holds
  `SLI_ASSERT_NEXT(a_out_hold, out_stall, out_valid_i && $stable({out_status_i, out_value_sum_i}))

endmodule

bind sorted_list_insert_delete_find sli_checker #(.DEPTH(DEPTH)) u_sli_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_status_i      (out_o.status),
  .out_position_i    (out_o.position),
  .out_entry_count_i (out_o.entry_count),
  .out_value_sum_i   (out_o.value_sum)
);

/* tb/sli_list_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sli_list_checker
// Watches the request and result channels of the sorted list. Every accepted
// request is applied to a local copy of the list, count and sum; the result it
// should produce is queued, and each accepted result is compared field by
// field with the oldest queued one.
// ----------------------------------------------------------------------------
module sli_list_checker #(
  parameter int unsigned DEPTH = sli_pkg::DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sli_in_if           in_mon_i,
  sli_out_if          out_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct {
    sli_pkg::status_e                  status;
    logic [sli_pkg::PosW-1:0]          position;
    logic [sli_pkg::PosW-1:0]          entry_count;
    logic signed [sli_pkg::SumW-1:0]   value_sum;
  } list_result_t;

  logic signed [sli_pkg::ValueW-1:0] entries_q [DEPTH];
  int unsigned                       entry_total;
  logic signed [sli_pkg::AccW-1:0]   sum_acc;
  list_result_t                      awaited_results [$];
  list_result_t                      want;
  int unsigned                       mismatch_count;

  // Applies one operation to the local list and returns the result it produces.
  function automatic list_result_t apply_list_op(
    input logic [1:0]                        op,
    input logic signed [sli_pkg::ValueW-1:0] value
  );
    list_result_t                    res;
    int unsigned                     hit;
    int unsigned                     slot;
    logic signed [sli_pkg::AccW-1:0] value_ext;
    res.status = sli_pkg::ST_OK;
    res.position = '0;
    value_ext = {{(sli_pkg::AccW - sli_pkg::ValueW){value[sli_pkg::ValueW-1]}}, value};
    hit = DEPTH;
    for (int unsigned i = 0; i < entry_total; i++)
      if (hit == DEPTH && entries_q[i] == value) hit = i;
    case (op)
      sli_pkg::OP_INSERT: begin
        if (entry_total >= DEPTH) begin
          res.status = sli_pkg::ST_FULL;
        end else begin
          slot = 0;
          while (slot < entry_total && entries_q[slot] < value) slot++;
          for (int unsigned i = entry_total; i > slot; i--) entries_q[i] = entries_q[i-1];
          entries_q[slot] = value;
          entry_total++;
          sum_acc = sum_acc + value_ext;
        end
      end
      sli_pkg::OP_DELETE: begin
        if (hit == DEPTH) begin
          res.status = sli_pkg::ST_NOT_FOUND;
        end else begin
          for (int unsigned i = hit; i + 1 < entry_total; i++) entries_q[i] = entries_q[i+1];
          entry_total--;
          sum_acc = sum_acc - value_ext;
        end
      end
      sli_pkg::OP_FIND: begin
        if (hit == DEPTH) res.status = sli_pkg::ST_NOT_FOUND;
        else res.position = sli_pkg::PosW'(hit + 1);
      end
      default: ;  // unused code: list untouched
    endcase
    res.entry_count = sli_pkg::PosW'(entry_total);
    res.value_sum = sum_acc[sli_pkg::SumW-1:0];
    return res;
  endfunction

  task automatic report_field(input string field, input longint exp_v, input longint got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", field, exp_v, got_v);
      mismatch_count++;
    end
  endtask

  // Request is applied before the result is checked, so a result accepted in
  // the same cycle as its request still finds its expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_results.delete();
      entry_total = 0;
      sum_acc = '0;
      mismatch_count = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (in_mon_i.valid && in_mon_i.ready)
        awaited_results.push_back(apply_list_op(in_mon_i.operation, in_mon_i.value));
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result transaction with no request outstanding");
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          report_field("status", longint'(want.status), longint'(out_mon_i.status));
          report_field("position", longint'(want.position), longint'(out_mon_i.position));
          report_field("entry_count", longint'(want.entry_count),
                       longint'(out_mon_i.entry_count));
          report_field("value_sum", longint'($signed(want.value_sum)),
                       longint'($signed(out_mon_i.value_sum)));
        end
      end
      fail_count_o <= mismatch_count;
      pending_o <= awaited_results.size();
    end
  end

endmodule

/* tb/tb_sorted_list_insert_delete_find.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_list_insert_delete_find
// Drives insert, delete and find requests into the sorted list: a directed
// run over empty, duplicate, extreme and full cases, then random traffic that
// alternates between growing and shrinking the list, with bursty requests and
// a stalling result side. Checking is done by sli_list_checker.
// ----------------------------------------------------------------------------
module tb_sorted_list_insert_delete_find;

  localparam int unsigned                       Depth    = sli_pkg::DefaultDepth;
  localparam logic [1:0]                        OpUnused = 2'd3;
  localparam logic signed [sli_pkg::ValueW-1:0] ValMax   = 32'sh7fff_ffff;
  localparam logic signed [sli_pkg::ValueW-1:0] ValMin   = 32'sh8000_0000;

  typedef enum {DRAIN_FREE, DRAIN_COIN, DRAIN_CADENCE, DRAIN_CHOKE} drain_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned fail_total;
  int unsigned results_outstanding;

  sli_in_if  in_ch ();
  sli_out_if out_ch ();

  sorted_list_insert_delete_find #(.DEPTH(Depth)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  sli_list_checker #(.DEPTH(Depth)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .fail_count_o (fail_total),
    .pending_o    (results_outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side back-pressure
  drain_mode_e drain_mode = DRAIN_FREE;
  int unsigned drain_left = 0;

  always @(posedge clk_i) begin
    if (drain_left == 0) begin
      drain_mode = drain_mode_e'($urandom_range(0, 3));
      drain_left = $urandom_range(4, 48);
    end
    drain_left--;
    case (drain_mode)
      DRAIN_FREE:    out_ch.ready <= 1'b1;
      DRAIN_COIN:    out_ch.ready <= 1'($urandom_range(0, 1));
      DRAIN_CADENCE: out_ch.ready <= (drain_left[1:0] != 2'd0);
      default:       out_ch.ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // stimulus-side record of what the list holds, for picking hits and flushing
  logic signed [sli_pkg::ValueW-1:0] held_vals [$];
  int unsigned                       burst_left = 0;

  task automatic send_item(input logic [1:0] op,
                           input logic signed [sli_pkg::ValueW-1:0] value);
    int unsigned gap;
    bit          removed;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        in_ch.operation <= 2'($urandom());
        in_ch.value <= $urandom();
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.value <= value;
    do @(posedge clk_i); while (!in_ch.ready);
    removed = 1'b0;
    if (op == sli_pkg::OP_INSERT && held_vals.size() < Depth) held_vals.push_back(value);
    if (op == sli_pkg::OP_DELETE)
      for (int i = 0; i < held_vals.size(); i++)
        if (!removed && held_vals[i] == value) begin
          held_vals.delete(i);
          removed = 1'b1;
        end
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (results_outstanding != 0);
    burst_left = 0;
  endtask

  // empty the list, fill it with one value past full, then look it up
  task automatic flush_and_saturate(input logic signed [sli_pkg::ValueW-1:0] fill_value);
    while (held_vals.size() != 0)
      send_item(sli_pkg::OP_DELETE, held_vals[$urandom_range(0, held_vals.size() - 1)]);
    for (int i = 0; i <= Depth; i++) send_item(sli_pkg::OP_INSERT, fill_value);
    send_item(sli_pkg::OP_FIND, fill_value);
  endtask

  function automatic logic signed [sli_pkg::ValueW-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35 && held_vals.size() != 0)
      return held_vals[$urandom_range(0, held_vals.size() - 1)];
    if (roll < 60) return 32'($urandom_range(0, 16)) - 32'd8;
    if (roll < 70)
      case ($urandom_range(0, 5))
        0:       return ValMax;
        1:       return ValMin;
        2:       return ValMax - 1;
        3:       return ValMin + 1;
        4:       return '0;
        default: return '1;
      endcase
    return $urandom();
  endfunction

  initial begin
    logic [1:0]  op_code;
    bit          growing;
    int unsigned phase_left;
    int unsigned roll;
    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= sli_pkg::OP_INSERT;
    in_ch.value <= '0;
    growing = 1'b1;
    phase_left = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, duplicates, extremes, absent values, full list
    send_item(sli_pkg::OP_FIND, '0);
    send_item(sli_pkg::OP_DELETE, 32'sd5);
    send_item(OpUnused, ValMax);
    send_item(sli_pkg::OP_INSERT, '0);
    send_item(sli_pkg::OP_INSERT, ValMax);
    send_item(sli_pkg::OP_INSERT, ValMin);
    send_item(sli_pkg::OP_INSERT, '0);
    send_item(sli_pkg::OP_INSERT, '1);
    send_item(sli_pkg::OP_FIND, '0);
    send_item(sli_pkg::OP_FIND, ValMin);
    send_item(sli_pkg::OP_FIND, ValMax);
    send_item(sli_pkg::OP_DELETE, '0);
    send_item(sli_pkg::OP_DELETE, 32'sd7);
    for (int i = 0; i < 12; i++) send_item(sli_pkg::OP_INSERT, 32'(i * 977) - 32'd5000);
    send_item(sli_pkg::OP_INSERT, 32'sd1);
    wait_all_results();

    // random: alternate phases biased toward insert or delete
    for (int n = 0; n < 600; n++) begin
      if (phase_left == 0) begin
        growing = !growing;
        phase_left = $urandom_range(5, 40);
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      if (roll < 3) op_code = OpUnused;
      else if (roll < 63) op_code = growing ? sli_pkg::OP_INSERT : sli_pkg::OP_DELETE;
      else if (roll < 83) op_code = growing ? sli_pkg::OP_DELETE : sli_pkg::OP_INSERT;
      else op_code = sli_pkg::OP_FIND;
      send_item(op_code, pick_value());
      if (n == 200) flush_and_saturate(ValMax);
      if (n == 400) flush_and_saturate(ValMin);
      if (n % 150 == 149) wait_all_results();
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (results_outstanding != 0);
    repeat (8) @(posedge clk_i);
    if (fail_total == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/sli_pkg.sv
hdl/sli_in_if.sv
hdl/sli_out_if.sv
hdl/sli_cell.sv
hdl/sorted_list_insert_delete_find.sv
hdl/sli_checker.sv
tb/sli_list_checker.sv
tb/tb_sorted_list_insert_delete_find.sv
